/* rtl/hsfd_pkg.sv */
// Shared types, codes and helpers for the heater status frame decoder.
// No dependencies; imported by every module of the block.
package hsfd_pkg;

    // Frame length defaults, in bytes including the checksum byte
    localparam int LONG_FRAME_BYTES_DEF  = 12;
    localparam int SHORT_FRAME_BYTES_DEF = 9;

    // Byte counter saturates at its all-ones value
    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Frame type codes and the short D2 signature in bytes 3..6
    localparam logic [7:0] TYPE_D1 = 8'hD1;
    localparam logic [7:0] TYPE_D2 = 8'hD2;
    localparam logic [7:0] SIG_B3  = 8'h2D;
    localparam logic [7:0] SIG_B4  = 8'h07;
    localparam logic [7:0] SIG_B5  = 8'h0D;
    localparam logic [7:0] SIG_B6  = 8'hA0;

    // Temperature byte fields
    localparam logic [7:0] TEMP_WHOLE_MASK = 8'h1F;
    localparam logic [7:0] TEMP_PLUS2_BIT  = 8'h40;
    localparam logic [7:0] TEMP_SIGN_BIT   = 8'h80;

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_BAD_LEN = 2'd1,
        STATUS_BAD_SUM = 2'd2
    } frame_status_t;

    typedef enum logic [1:0] {
        KIND_OTHER    = 2'd0,
        KIND_LONG_D1  = 2'd1,
        KIND_LONG_D2  = 2'd2,
        KIND_SHORT_D2 = 2'd3
    } frame_kind_t;

    // Frame state as seen while the current byte is being taken,
    // with the current byte already merged into the stored bytes
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         sum;
        logic               overlong;
        logic [7:0]         b0;
        logic [7:0]         b2;
        logic [7:0]         b3;
        logic [7:0]         b4;
        logic [7:0]         b5;
        logic [7:0]         b6;
        logic [7:0]         b8;
        logic [7:0]         b9;
    } frame_ctx_t;

    typedef struct packed {
        frame_status_t     status;
        logic [7:0]        type_code;
        frame_kind_t       kind;
        logic signed [7:0] inlet_temp_half;
        logic              flow_detected;
        logic signed [7:0] cond_temp_a;
        logic signed [7:0] cond_temp_b;
        logic signed [7:0] cond_temp_c;
        logic signed [7:0] cond_temp_d;
        logic [7:0]        target_temp;
    } frame_result_t;

    // Sign-magnitude temperature byte to two's complement half degrees;
    // bits 5..1 doubled plus bit 0 is simply bits 5..0
    function automatic logic signed [7:0] half_degrees(input logic [7:0] v);
        logic [7:0] mag;
        begin
            mag = {2'b00, v[5:0]};
            if ((v & TEMP_PLUS2_BIT) != 8'h00)
            begin
                mag = mag + 8'd4;
            end
            if ((v & TEMP_SIGN_BIT) != 8'h00)
            begin
                mag = 8'd0 - mag;
            end
            return mag;
        end
    endfunction

endpackage

/* rtl/hsfd_accum.sv */
// Frame accumulator: byte count, running checksum, overlong flag, frame bytes.
// Depends on hsfd_pkg.
module hsfd_accum
    import hsfd_pkg::*;
#(
    parameter int LONG_FRAME_BYTES = LONG_FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output frame_ctx_t ctx
);

    localparam int IDX_W = $clog2(LONG_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] STORE_LIMIT = COUNT_W'(LONG_FRAME_BYTES);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    logic               overlong_reg;
    logic               overlong_next;
    logic [7:0]         store_reg [LONG_FRAME_BYTES];

    // Read a stored byte, taking the current byte when it lands there
    function automatic logic [7:0] pick(input logic [COUNT_W-1:0] pos,
                                        input logic [7:0]         stored);
        begin
            return (count_reg == pos) ? data_byte : stored;
        end
    endfunction

    always_comb
    begin
        count_next    = count_reg;
        sum_next      = sum_reg;
        overlong_next = overlong_reg;
        if (last_byte)
        begin
            count_next    = '0;
            sum_next      = '0;
            overlong_next = 1'b0;
        end
        else
        begin
            sum_next = sum_reg + data_byte;
            if (count_reg == COUNT_MAX)
            begin
                overlong_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            overlong_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            overlong_reg <= overlong_next;
        end
    end

    // Hold frame bytes; positions past the store are counted only
    always_ff @(posedge clk)
    begin
        if (step && (count_reg < STORE_LIMIT))
        begin
            store_reg[count_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    always_comb
    begin
        ctx.count    = count_reg;
        ctx.sum      = sum_reg;
        ctx.overlong = overlong_reg;
        ctx.b0       = pick(COUNT_W'(0), store_reg[0]);
        ctx.b2       = pick(COUNT_W'(2), store_reg[2]);
        ctx.b3       = pick(COUNT_W'(3), store_reg[3]);
        ctx.b4       = pick(COUNT_W'(4), store_reg[4]);
        ctx.b5       = pick(COUNT_W'(5), store_reg[5]);
        ctx.b6       = pick(COUNT_W'(6), store_reg[6]);
        ctx.b8       = pick(COUNT_W'(8), store_reg[8]);
        ctx.b9       = pick(COUNT_W'(9), store_reg[9]);
    end

endmodule

/* rtl/hsfd_decode.sv */
// Frame end checks (length, checksum) and condition field decode.
// Depends on hsfd_pkg.
module hsfd_decode
    import hsfd_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF
)
(
    input  frame_ctx_t    ctx,
    input  logic [7:0]    checksum,
    output frame_result_t result
);

    localparam int LEN_W = COUNT_W + 1;
    localparam logic [LEN_W-1:0] LONG_LEN  = LEN_W'(LONG_FRAME_BYTES);
    localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(SHORT_FRAME_BYTES);

    logic [LEN_W-1:0] len;
    logic             is_long;
    logic             is_short;
    logic [7:0]       expect_sum;
    logic             sig_ok;

    always_comb
    begin
        len        = {1'b0, ctx.count} + LEN_W'(1);
        is_long    = (len == LONG_LEN);
        is_short   = (len == SHORT_LEN);
        // Short frames leave the type byte out of the checksum
        expect_sum = is_short ? (ctx.sum - ctx.b0) : ctx.sum;
        sig_ok     = (ctx.b3 == SIG_B3) && (ctx.b4 == SIG_B4) &&
                     (ctx.b5 == SIG_B5) && (ctx.b6 == SIG_B6);

        result           = '0;
        result.type_code = ctx.b0;

        if (ctx.overlong || !(is_long || is_short))
        begin
            result.status = STATUS_BAD_LEN;
        end
        else if (expect_sum != checksum)
        begin
            result.status = STATUS_BAD_SUM;
        end
        else
        begin
            result.status = STATUS_GOOD;
        end

        if (result.status == STATUS_GOOD)
        begin
            if (is_long && (ctx.b0 == TYPE_D1))
            begin
                result.kind            = KIND_LONG_D1;
                result.inlet_temp_half = half_degrees(ctx.b9);
                result.flow_detected   = ctx.b3[1];
            end
            else if (is_long && (ctx.b0 == TYPE_D2))
            begin
                result.kind        = KIND_LONG_D2;
                result.cond_temp_a = half_degrees(ctx.b4);
                result.cond_temp_b = half_degrees(ctx.b6);
                result.cond_temp_c = half_degrees(ctx.b5);
                result.cond_temp_d = half_degrees(ctx.b8);
            end
            else if (is_short && (ctx.b0 == TYPE_D2) && sig_ok)
            begin
                result.kind        = KIND_SHORT_D2;
                result.target_temp = ctx.b2;
            end
            else
            begin
                result.kind = KIND_OTHER;
            end
        end
    end

endmodule

/* rtl/heater_status_frame_decoder_top.sv */
// Top level of the heater status frame decoder: input register, accumulator,
// decode and result register. Depends on hsfd_pkg, hsfd_accum, hsfd_decode.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, data_byte, last_byte       | request in
//   out     | out_valid, out_stall, frame_status .. target   | request out
//
// One byte request per cycle, unless a last byte waits on a stalled result. A
// byte is accepted into the input register; a last byte then writes the result
// register as it advances, which raises out_valid; the result is then held
// while out_stall is high. The running sum update and at most one store write
// per byte fit between the input and result registers.
// Reset clears the byte count, running sum, overlong flag and both valid
// flags; stored frame bytes are left as they are.
// Bytes that are not the last of a frame keep flowing while a result is held
// under out_stall; only a last byte waits for the result register to free.
module heater_status_frame_decoder_top
    import hsfd_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        frame_status,
    output logic [7:0]        type_code,
    output logic [1:0]        frame_kind,
    output logic signed [7:0] inlet_temp_half,
    output logic              flow_detected,
    output logic signed [7:0] cond_temp_a,
    output logic signed [7:0] cond_temp_b,
    output logic signed [7:0] cond_temp_c,
    output logic signed [7:0] cond_temp_d,
    output logic [7:0]        target_temp
);

    // Input register
    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;

    // Result register
    logic          out_valid_reg;
    frame_result_t result_reg;
    frame_result_t result_next;

    logic          in_take;
    logic          advance;
    frame_ctx_t    ctx;

    // Advance the held byte unless it ends a frame and the result slot is
    // still occupied by a stalled result
    always_comb
    begin
        advance  = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
        in_stall = in_valid_reg && !advance;
        in_take  = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (advance && last_reg)
        begin
            result_reg <= result_next;
        end
    end

    hsfd_accum #(
        .LONG_FRAME_BYTES (LONG_FRAME_BYTES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .ctx       (ctx)
    );

    hsfd_decode #(
        .LONG_FRAME_BYTES  (LONG_FRAME_BYTES),
        .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES)
    ) u_decode (
        .ctx      (ctx),
        .checksum (byte_reg),
        .result   (result_next)
    );

    // Drive the result ports from the result register
    assign out_valid       = out_valid_reg;
    assign frame_status    = result_reg.status;
    assign type_code       = result_reg.type_code;
    assign frame_kind      = result_reg.kind;
    assign inlet_temp_half = result_reg.inlet_temp_half;
    assign flow_detected   = result_reg.flow_detected;
    assign cond_temp_a     = result_reg.cond_temp_a;
    assign cond_temp_b     = result_reg.cond_temp_b;
    assign cond_temp_c     = result_reg.cond_temp_c;
    assign cond_temp_d     = result_reg.cond_temp_d;
    assign target_temp     = result_reg.target_temp;

endmodule

/* rtl/hsfd_checker.sv */
// Port-level checks for the heater status frame decoder, bound to the top.
// Depends on hsfd_pkg and heater_status_frame_decoder_top.
module hsfd_checker
    import hsfd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [7:0]        data_byte,
    input logic              last_byte,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        frame_status,
    input logic [7:0]        type_code,
    input logic [1:0]        frame_kind,
    input logic signed [7:0] inlet_temp_half,
    input logic              flow_detected,
    input logic signed [7:0] cond_temp_a,
    input logic signed [7:0] cond_temp_b,
    input logic signed [7:0] cond_temp_c,
    input logic signed [7:0] cond_temp_d,
    input logic [7:0]        target_temp
);

    // A stalled result holds its valid, status, kind and type code
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_status) &&
        $stable(frame_kind) && $stable(type_code))
        else $error("result changed while stalled");

    // A bad frame is never decoded
    a_bad_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status != STATUS_GOOD) |-> frame_kind == KIND_OTHER)
        else $error("bad frame carries a frame kind");

    // Kinds match their frame type byte
    a_kind_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_kind != KIND_OTHER) |->
        (frame_kind == KIND_LONG_D1) ? (type_code == TYPE_D1)
                                     : (type_code == TYPE_D2))
        else $error("frame kind does not match frame type");

    // Inlet fields stay zero outside long D1 frames
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_kind != KIND_LONG_D1) |->
        (inlet_temp_half == 8'sd0) && !flow_detected)
        else $error("inlet fields set outside long D1");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_status == STATUS_GOOD) ||
        (frame_status == STATUS_BAD_LEN) || (frame_status == STATUS_BAD_SUM))
        else $error("undefined frame status");

endmodule

bind heater_status_frame_decoder_top hsfd_checker u_checker (.*);
